// ===== rtl/abec_pkg.sv =====
// ----------------------------------------------------------------------------
// abec_pkg - shared types and constants for the auto-baud edge bit capture
// Field widths, input mode codes, learn phase codes and the stop byte.
// ----------------------------------------------------------------------------
package abec_pkg;

  localparam int BYTE_BITS = 8;
  localparam int TICK_BITS = 32;
  localparam int IDX_BITS  = 6;
  localparam int TOTAL_BITS = 10;

  typedef logic [BYTE_BITS-1:0] byte_t;
  typedef logic [TICK_BITS-1:0] tick_t;

  localparam byte_t STOP_BYTE = 8'hFF;
  localparam byte_t MSB_MASK  = 8'h80;

  typedef enum logic [1:0] {
    MODE_EDGE    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_RUN    = 3'b100
  } phase_t;

endpackage

// ===== rtl/autobaud_edge_bit_capture.sv =====
// ----------------------------------------------------------------------------
// autobaud_edge_bit_capture - auto-baud serial bit receiver on line edges
// Learns the bit period from the time between the first and second line edge, then captures inverted levels into a
// byte store, msb first, until a 0xFF byte or a full store.
// ----------------------------------------------------------------------------
// latency: one result per beat, valid the cycle after the input beat is taken
// throughput: one beat per cycle unless out_stall holds the output; the store
//   takes one byte write and one read per cycle, the open byte is forwarded
// reset (rst, synchronous) and the restart mode clear all control state; the
//   store is cleared through the bit count fill mark, with no clearing pass
// ----------------------------------------------------------------------------
module autobaud_edge_bit_capture #(
  parameter int STORE_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic                              level,
  input  abec_pkg::tick_t                   tick,
  input  logic [abec_pkg::IDX_BITS-1:0]     read_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              captured,
  output logic                              bit_value,
  output logic [abec_pkg::TOTAL_BITS-1:0]   bit_total,
  output abec_pkg::byte_t                   byte_value,
  output logic                              finished,
  output abec_pkg::tick_t                   period_out
);
  import abec_pkg::*;

  localparam int FULL_BITS = STORE_BYTES * BYTE_BITS;
  localparam int CW = $clog2(FULL_BITS + 1);
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int KW = (CW > IDX_BITS + 3) ? CW : IDX_BITS + 3;
  localparam int TW = TICK_BITS + 2;

  // control state
  logic          run_flag, run_flag_next;
  phase_t        phase, phase_next;
  tick_t         first_edge_time, first_edge_time_next;
  tick_t         learned_period, learned_period_next;
  logic [TW-1:0] thr3, thr3_next;
  tick_t         last_capture_time, last_capture_time_next;
  logic [CW-1:0] bit_counter, bit_counter_next;
  byte_t         cur_byte;

  // output side
  byte_t         byte_q;
  logic          rd_sel;
  byte_t         rd_data;

  logic          in_acc;
  tick_t         diff, learn_diff;
  logic [TW-1:0] learn_thr;
  logic          over;
  logic [2:0]    sh;
  logic          bit_new;
  byte_t         byte_new;
  logic [CW-1:0] cnt_inc;
  logic          wr_en, rd_en, rd_hit, cap;
  byte_t         byte_o;
  logic [AW-1:0] wr_addr, rd_addr;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign diff       = tick - last_capture_time;
  assign over       = {diff, 2'b00} > thr3;
  assign learn_diff = tick - first_edge_time;
  assign learn_thr  = TW'({learn_diff, 1'b0}) + TW'(learn_diff);

  assign sh      = bit_counter[2:0];
  assign bit_new = ~level;
  // first bit of a byte starts from a cleared entry, later bits use the open byte
  assign byte_new = ((sh == 3'd0) ? byte_t'(0) : cur_byte) |
                    (bit_new ? (MSB_MASK >> sh) : byte_t'(0));
  assign cnt_inc  = bit_counter + CW'(1);
  assign wr_addr  = AW'(bit_counter >> 3);
  assign rd_addr  = AW'(read_index);

  always_comb begin
    run_flag_next          = run_flag;
    phase_next             = phase;
    first_edge_time_next   = first_edge_time;
    learned_period_next    = learned_period;
    thr3_next              = thr3;
    last_capture_time_next = last_capture_time;
    bit_counter_next       = bit_counter;
    cap    = 1'b0;
    byte_o = '0;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    rd_hit = 1'b0;
    if (in_acc) begin
      case (mode)
        MODE_EDGE: begin
          if (run_flag) begin
            case (phase)
              PH_FIRST: begin
                first_edge_time_next = tick;
                phase_next           = PH_SECOND;
              end
              PH_SECOND: begin
                learned_period_next    = learn_diff;
                thr3_next              = learn_thr;
                last_capture_time_next = tick;
                phase_next             = PH_RUN;
              end
              PH_RUN: begin
                if (over) begin
                  cap    = 1'b1;
                  wr_en  = 1'b1;
                  byte_o = byte_new;
                  bit_counter_next       = cnt_inc;
                  last_capture_time_next = tick;
                  if (byte_new == STOP_BYTE || cnt_inc >= CW'(FULL_BITS)) begin
                    run_flag_next = 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        MODE_RESTART: begin
          run_flag_next          = 1'b1;
          phase_next             = PH_FIRST;
          first_edge_time_next   = '0;
          learned_period_next    = '0;
          thr3_next              = '0;
          last_capture_time_next = '0;
          bit_counter_next       = '0;
        end
        MODE_READ: begin
          rd_en  = 1'b1;
          // entry holds data only once a bit has landed in it
          rd_hit = KW'({read_index, 3'b000}) < KW'(bit_counter);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag          <= 1'b1;
      phase             <= PH_FIRST;
      first_edge_time   <= '0;
      learned_period    <= '0;
      thr3              <= '0;
      last_capture_time <= '0;
      bit_counter       <= '0;
    end else begin
      run_flag          <= run_flag_next;
      phase             <= phase_next;
      first_edge_time   <= first_edge_time_next;
      learned_period    <= learned_period_next;
      thr3              <= thr3_next;
      last_capture_time <= last_capture_time_next;
      bit_counter       <= bit_counter_next;
    end
  end

  // forwarded copy of the entry being filled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cur_byte <= byte_new;
    end
  end

  abec_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (byte_new),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      captured   <= cap;
      bit_value  <= cap && bit_new;
      bit_total  <= TOTAL_BITS'(bit_counter_next);
      byte_q     <= byte_o;
      rd_sel     <= rd_hit;
      finished   <= !run_flag_next;
      period_out <= learned_period_next;
    end
  end

  assign byte_value = rd_sel ? rd_data : byte_q;

  // restart leaves a cleared, running reader
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && mode == MODE_RESTART) |=>
      (bit_counter == '0 && run_flag && phase == PH_FIRST))
    else $error("restart did not clear reader state");

  // a held capture beat can only come from the running phase
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && captured) |-> (phase == PH_RUN))
    else $error("capture reported outside running phase");

  // once stopped, only a restart moves the bit count
  assert property (@(posedge clk) disable iff (rst)
    (!run_flag && !(in_acc && mode == MODE_RESTART)) |=> $stable(bit_counter))
    else $error("bit count moved while stopped");

  // bit count never passes a full store
  assert property (@(posedge clk) disable iff (rst)
    KW'(bit_counter) <= KW'(FULL_BITS))
    else $error("bit count beyond store size");

endmodule

// ===== rtl/abec_store.sv =====
// ----------------------------------------------------------------------------
// abec_store - byte store memory
// One write port and one read port, read data registered, held when idle.
// ----------------------------------------------------------------------------
module abec_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  abec_pkg::byte_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output abec_pkg::byte_t rd_data
);
  import abec_pkg::*;

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/autobaud_edge_bit_capture_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// autobaud_edge_bit_capture_tb - self-checking bench for the edge bit capture
// Streams restart, learning-edge, capture-edge and store-read beats into the
// block. Each accepted beat is run through a behavioral receiver model, and
// the resulting report is checked field by field against the block's output.
// ----------------------------------------------------------------------------
module autobaud_edge_bit_capture_tb;
  import abec_pkg::*;

  localparam int STORE_BYTES  = 64;
  localparam int STORE_BITS   = STORE_BYTES * BYTE_BITS;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 30;

  typedef struct {
    mode_t                mode;
    logic                 level;
    tick_t                tick;
    logic [IDX_BITS-1:0]  read_index;
    bit                   hold;
  } line_beat_t;

  typedef struct {
    logic                   captured;
    logic                   bit_value;
    logic [TOTAL_BITS-1:0]  bit_total;
    byte_t                  byte_value;
    logic                   finished;
    tick_t                  period_out;
  } rx_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             mode = MODE_EDGE;
  logic                   level = 1'b0;
  tick_t                  tick = '0;
  logic [IDX_BITS-1:0]    read_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   captured;
  logic                   bit_value;
  logic [TOTAL_BITS-1:0]  bit_total;
  byte_t                  byte_value;
  logic                   finished;
  tick_t                  period_out;

  autobaud_edge_bit_capture #(.STORE_BYTES(STORE_BYTES)) DUT (.*);

  always #5 clk = ~clk;

  // receiver model state
  logic    rx_running;
  phase_t  rx_phase;
  tick_t   first_tick;
  tick_t   bit_period;
  tick_t   last_cap_tick;
  int      bits_taken;
  byte_t   store_img [STORE_BYTES];

  line_beat_t  line_beats [$];
  rx_report_t  expected_reports [$];
  line_beat_t  on_wire;
  rx_report_t  want;
  rx_report_t  seen;

  int unsigned n_predicted = 0;
  int unsigned n_checked = 0;
  int unsigned total_beats = 0;
  int unsigned n_errors = 0;
  int unsigned n_captures = 0;
  int unsigned n_stop_byte = 0;
  int unsigned n_full_store = 0;
  logic [1:0]  load_stage = 2'd0;

  function automatic void clear_receiver();
    rx_running    = 1'b1;
    rx_phase      = PH_FIRST;
    first_tick    = '0;
    bit_period    = '0;
    last_cap_tick = '0;
    bits_taken    = 0;
    foreach (store_img[i]) store_img[i] = '0;
  endfunction

  function automatic rx_report_t predict_report(line_beat_t b);
    rx_report_t r;
    logic [63:0] span4;
    logic [63:0] limit3;
    int pos;
    r.captured   = 1'b0;
    r.bit_value  = 1'b0;
    r.byte_value = '0;
    case (b.mode)
      MODE_EDGE: begin
        if (rx_running) begin
          if (rx_phase == PH_FIRST) begin
            first_tick = b.tick;
            rx_phase   = PH_SECOND;
          end else if (rx_phase == PH_SECOND) begin
            bit_period    = b.tick - first_tick;
            last_cap_tick = b.tick;
            rx_phase      = PH_RUN;
          end else begin
            // exact 3/4 period threshold on the wrapped tick difference
            span4  = {30'd0, tick_t'(b.tick - last_cap_tick), 2'b00};
            limit3 = 64'd3 * {32'd0, bit_period};
            if (span4 > limit3) begin
              pos         = bits_taken / BYTE_BITS;
              r.bit_value = ~b.level;
              if (r.bit_value)
                store_img[pos] = store_img[pos] | (MSB_MASK >> (bits_taken % BYTE_BITS));
              r.byte_value  = store_img[pos];
              r.captured    = 1'b1;
              bits_taken    = bits_taken + 1;
              last_cap_tick = b.tick;
              n_captures++;
              if (r.byte_value == STOP_BYTE) begin
                rx_running = 1'b0;
                n_stop_byte++;
              end else if (bits_taken >= STORE_BITS) begin
                rx_running = 1'b0;
                n_full_store++;
              end
            end
          end
        end
      end
      MODE_RESTART: clear_receiver();
      MODE_READ:    r.byte_value = store_img[b.read_index];
      default: ;
    endcase
    r.bit_total  = TOTAL_BITS'(bits_taken);
    r.finished   = ~rx_running;
    r.period_out = bit_period;
    return r;
  endfunction

  function automatic int idle_pct(logic [1:0] stage, bit sender);
    if (stage == 2'd0) return sender ? 23 : 76;
    if (stage == 2'd1) return sender ? 76 : 23;
    return 0;
  endfunction

  task automatic push_beat(mode_t m, logic lvl, tick_t t, int idx, bit hold = 1'b0);
    line_beat_t b;
    b.mode       = m;
    b.level      = lvl;
    b.tick       = t;
    b.read_index = IDX_BITS'(idx);
    b.hold       = hold;
    line_beats.push_back(b);
  endtask

  // one receive session: an optional restart, two learning edges, then bit edges
  task automatic queue_session(bit fill_store, bit hold);
    tick_t   t0;
    tick_t   cap_t;
    longint  per;
    longint  lo;
    longint  hi;
    longint  gap;
    int      edges;
    int      zero_pct;
    int      n_cap;
    mode_t   m;
    logic    lvl;
    n_cap = 0;
    // pure noise now and then, continuing from whatever state is left
    if (!fill_store && !hold && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 12)) begin
        case ($urandom_range(0, 5))
          0:       m = MODE_RESTART;
          1, 2:    m = MODE_READ;
          default: m = MODE_EDGE;
        endcase
        push_beat(m, 1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 63));
      end
      return;
    end
    if (fill_store) per = $urandom_range(10, 200);
    else case ($urandom_range(0, 9))
      0:       per = 0;
      1:       per = longint'($urandom);
      default: per = $urandom_range(4, 5000);
    endcase
    case ($urandom_range(0, 3))
      0:       zero_pct = 100;
      1:       zero_pct = 90;
      default: zero_pct = 50;
    endcase
    if (fill_store) zero_pct = 50;
    if (hold || fill_store || $urandom_range(0, 7) != 0)
      push_beat(MODE_RESTART, 1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 63),
                hold);
    t0    = $urandom;
    cap_t = t0 + tick_t'(per);
    push_beat(MODE_EDGE, 1'($urandom_range(0, 1)), t0, $urandom_range(0, 63));
    push_beat(MODE_EDGE, 1'($urandom_range(0, 1)), cap_t, $urandom_range(0, 63));
    edges = fill_store ? STORE_BITS + 6 : $urandom_range(3, 40);
    for (int i = 0; i < edges; i++) begin
      if (!fill_store && $urandom_range(0, 14) == 0)
        push_beat(MODE_READ, 1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 63));
      if (!fill_store && $urandom_range(0, 6) == 0) begin
        // glitch edge inside the 3/4 window, no capture
        hi  = (3 * per) / 4;
        gap = longint'($urandom) % (hi + 1);
        push_beat(MODE_EDGE, 1'($urandom_range(0, 1)), cap_t + tick_t'(gap),
                  $urandom_range(0, 63));
      end else begin
        lo = (3 * per) / 4 + 1;
        hi = (5 * per) / 4;
        if (hi > longint'(32'hFFFF_FFFF)) hi = longint'(32'hFFFF_FFFF);
        if (hi < lo) hi = lo;
        gap   = lo + longint'($urandom) % (hi - lo + 1);
        cap_t = cap_t + tick_t'(gap);
        if (fill_store && n_cap % BYTE_BITS == BYTE_BITS - 1)
          lvl = 1'b1;  // lsb of each byte stays 0 so no stop byte forms
        else
          lvl = ($urandom_range(0, 99) < zero_pct) ? 1'b0 : 1'b1;
        push_beat(MODE_EDGE, lvl, cap_t, $urandom_range(0, 63));
        n_cap++;
      end
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) == 0)
        push_beat(MODE_READ, 1'($urandom_range(0, 1)), $urandom,
                  (n_cap / BYTE_BITS) % STORE_BYTES);
      else
        push_beat(MODE_READ, 1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 63));
    end
  endtask

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      n_errors++;
      if (n_errors <= MAX_PRINTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      clear_receiver();
    end else begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_report(on_wire));
        n_predicted++;
      end
      if (!in_valid || !in_stall) begin
        if (line_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct(load_stage, 1'b1)
            && !(line_beats[0].hold && n_predicted != n_checked)) begin
          on_wire    = line_beats.pop_front();
          mode       <= on_wire.mode;
          level      <= on_wire.level;
          tick       <= on_wire.tick;
          read_index <= on_wire.read_index;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (n_predicted < total_beats / 3) load_stage <= 2'd0;
      else if (n_predicted < 2 * total_beats / 3) load_stage <= 2'd1;
      else load_stage <= 2'd2;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.captured   = captured;
        seen.bit_value  = bit_value;
        seen.bit_total  = bit_total;
        seen.byte_value = byte_value;
        seen.finished   = finished;
        seen.period_out = period_out;
        if (expected_reports.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_PRINTS)
            $display("%0t: unexpected report, expected none actual period %0h total %0h",
                     $time, seen.period_out, seen.bit_total);
        end else begin
          want = expected_reports.pop_front();
          check_field("captured", 32'(want.captured), 32'(seen.captured));
          check_field("bit_value", 32'(want.bit_value), 32'(seen.bit_value));
          check_field("bit_total", 32'(want.bit_total), 32'(seen.bit_total));
          check_field("byte_value", 32'(want.byte_value), 32'(seen.byte_value));
          check_field("finished", 32'(want.finished), 32'(seen.finished));
          check_field("period_out", want.period_out, seen.period_out);
        end
        n_checked <= n_checked + 1;
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct(load_stage, 1'b0));
    end
  end

  initial begin
    // reset state, then the 3/4 threshold exactly at and just past the edge
    push_beat(MODE_READ, 1'b0, 32'h0, 0);
    push_beat(MODE_READ, 1'b1, 32'hFFFF_FFFF, 63);
    push_beat(MODE_EDGE, 1'b1, 32'hFFFF_FFF0, 0);   // period wraps through zero
    push_beat(MODE_EDGE, 1'b0, 32'h0000_0010, 0);
    push_beat(MODE_EDGE, 1'b0, 32'h0000_0028, 0);
    push_beat(MODE_EDGE, 1'b0, 32'h0000_0029, 0);
    push_beat(MODE_READ, 1'b0, 32'h0, 0);
    push_beat(MODE_RESTART, 1'b0, 32'h0, 0);
    // zero period, then a stop byte, then an ignored edge
    push_beat(MODE_EDGE, 1'b0, 32'd5, 0);
    push_beat(MODE_EDGE, 1'b1, 32'd5, 0);
    push_beat(MODE_EDGE, 1'b0, 32'd5, 0);
    for (int i = 0; i < BYTE_BITS; i++) push_beat(MODE_EDGE, 1'b0, 32'd6 + i, 0);
    push_beat(MODE_EDGE, 1'b0, 32'd100, 0);
    push_beat(MODE_READ, 1'b0, 32'h0, 0);
    push_beat(MODE_RESTART, 1'b1, 32'hFFFF_FFFF, 63);
    // largest period, threshold on the 64-bit product
    push_beat(MODE_EDGE, 1'b0, 32'h0, 0);
    push_beat(MODE_EDGE, 1'b1, 32'hFFFF_FFFF, 0);
    push_beat(MODE_EDGE, 1'b1, 32'hBFFF_FFFE, 0);
    push_beat(MODE_EDGE, 1'b1, 32'hBFFF_FFFF, 0);
    queue_session(1'b0, 1'b1);
    while (line_beats.size() < 300) queue_session(1'b0, $urandom_range(0, 19) == 0);
    queue_session(1'b1, 1'b0);
    while (line_beats.size() < 900) queue_session(1'b0, $urandom_range(0, 19) == 0);
    total_beats = line_beats.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (line_beats.size() != 0 || in_valid || n_checked != n_predicted) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_reports.size() != 0) begin
      n_errors++;
      $display("%0t: %0d reports still expected, actual none", $time,
               expected_reports.size());
    end
    $display("ran %0d beats: %0d bits captured, %0d stops on a 0xff byte, %0d on a full store",
             n_predicted, n_captures, n_stop_byte, n_full_store);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d of %0d beats checked", n_checked, total_beats);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
